// ----- hw/rtl/led_matrix_bcm_scan_driver_unit_assert.svh -----
// Assertion helpers for the LED matrix scan driver.
// Every assertion is clocked on the rising edge and is off while reset is low.
`ifndef LED_MATRIX_BCM_SCAN_DRIVER_UNIT_ASSERT_SVH
`define LED_MATRIX_BCM_SCAN_DRIVER_UNIT_ASSERT_SVH

// Same-cycle implication
`define LEDBCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ledbcm assertion failed");

// Next-cycle implication
`define LEDBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ledbcm assertion failed");

`endif

// ----- hw/rtl/ledbcm_pkg.sv -----
`timescale 1ns / 1ps

package ledbcm_pkg;

  // Panel geometry and modulation depth
  localparam int NumScenes    = 6;
  localparam int PanelColumns = 64;
  localparam int ScanRows     = 16;
  localparam int BcmPlanes    = 5;

  localparam int StoreDepth = NumScenes * ScanRows * PanelColumns;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ColW       = $clog2(PanelColumns);
  localparam int RowW       = $clog2(ScanRows);
  localparam int SceneW     = (NumScenes > 1) ? $clog2(NumScenes) : 1;
  localparam int SlotCount  = (1 << BcmPlanes) - 1;
  localparam int PixelW     = 24;

  localparam logic [15:0] FrameHoldReset = 16'd70;

  // Request codes
  typedef enum logic [1:0] {
    ReqPixel    = 2'd0,
    ReqScanTick = 2'd1,
    ReqMsTick   = 2'd2
  } req_e;

  // Register indexes
  localparam logic CfgScanEnable = 1'b0;
  localparam logic CfgFrameHold  = 1'b1;

  // One scan beat handed from the sequencer to the output stage
  typedef struct packed {
    logic       is_data;     // pixel bits come from the frame store
    logic [2:0] bit_sel;     // color bit shown in this slot
    logic       shift_clock;
    logic       latch;
    logic       blank;
    logic [3:0] row_select;
  } beat_t;

  // Color bit for a slot: 7 minus the trailing ones of the slot number
  function automatic logic [2:0] slot_bit(input logic [BcmPlanes-1:0] slot);
    logic [3:0] plane;
    logic       run;
    plane = '0;
    run   = 1'b1;
    for (int i = 0; i < BcmPlanes; i++) begin
      if (run && slot[i]) begin
        plane = plane + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return 3'(4'd7 - plane);
  endfunction

  // Pick one bit plane of a packed pixel: bit0 red, bit1 green, bit2 blue
  function automatic logic [2:0] plane_rgb(input logic [PixelW-1:0] rgb,
                                           input logic [2:0] sel);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    return {b[sel], g[sel], r[sel]};
  endfunction

endpackage

// ----- hw/rtl/ledbcm_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module ledbcm_ram #(
  parameter int Width = 24,
  parameter int Depth = 6144,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/ledbcm_ctrl.sv -----
`timescale 1ns / 1ps

// Scan sequencer, scene timer, config registers and frame store addressing
module ledbcm_ctrl import ledbcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              acc_i,
  input  logic [1:0]        req_type_i,
  input  logic [2:0]        scene_i,
  input  logic [4:0]        pixel_row_i,
  input  logic [5:0]        pixel_col_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              top_we_o,
  output logic              bot_we_o,
  output logic [AddrW-1:0]  top_waddr_o,
  output logic [AddrW-1:0]  bot_waddr_o,
  output logic [PixelW-1:0] wdata_o,
  output logic              rd_en_o,
  output logic [AddrW-1:0]  rd_addr_o,
  output logic              beat_valid_o,
  output beat_t             beat_o
);

  typedef enum logic [2:0] {
    PhData    = 3'd0,
    PhClkLow  = 3'd1,
    PhBlank   = 3'd2,
    PhLatch   = 3'd3,
    PhRow     = 3'd4,
    PhUnlatch = 3'd5,
    PhUnblank = 3'd6
  } phase_e;

  logic                 scan_en_q, scan_en_d;
  logic [15:0]          hold_q, hold_d;
  phase_e               phase_q, phase_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [BcmPlanes-1:0] slot_q, slot_d;
  logic [SceneW-1:0]    scene_q, scene_d;
  logic [15:0]          ms_q, ms_d;
  logic                 due_q, due_d;
  logic                 pin_clk_q, pin_clk_d;
  logic                 pin_latch_q, pin_latch_d;
  logic                 pin_blank_q, pin_blank_d;
  logic [3:0]           pin_row_q, pin_row_d;
  logic                 is_data;
  logic                 tick;
  logic                 scene_ok, col_ok, row_top, row_bot;

  // Pixel write decode
  assign scene_ok = 32'(scene_i) < 32'(NumScenes);
  assign col_ok   = 32'(pixel_col_i) < 32'(PanelColumns);
  assign row_top  = 32'(pixel_row_i) < 32'(ScanRows);
  assign row_bot  = !row_top && (32'(pixel_row_i) < 32'(2 * ScanRows));

  assign top_we_o = acc_i && (req_type_i == ReqPixel) && scene_ok && col_ok && row_top;
  assign bot_we_o = acc_i && (req_type_i == ReqPixel) && scene_ok && col_ok && row_bot;
  assign top_waddr_o = AddrW'(32'(scene_i) * 32'(ScanRows * PanelColumns)
                            + 32'(pixel_row_i) * 32'(PanelColumns) + 32'(pixel_col_i));
  assign bot_waddr_o = AddrW'(32'(scene_i) * 32'(ScanRows * PanelColumns)
                            + (32'(pixel_row_i) - 32'(ScanRows)) * 32'(PanelColumns)
                            + 32'(pixel_col_i));
  assign wdata_o = {red_i, green_i, blue_i};

  // Frame store read for the current scan position
  assign rd_addr_o = AddrW'(32'(scene_q) * 32'(ScanRows * PanelColumns)
                          + 32'(row_q) * 32'(PanelColumns) + 32'(col_q));

  assign tick = acc_i && (req_type_i == ReqScanTick);

  // Next state
  always_comb begin
    scan_en_d   = scan_en_q;
    hold_d      = hold_q;
    phase_d     = phase_q;
    col_d       = col_q;
    row_d       = row_q;
    slot_d      = slot_q;
    scene_d     = scene_q;
    ms_d        = ms_q;
    due_d       = due_q;
    pin_clk_d   = pin_clk_q;
    pin_latch_d = pin_latch_q;
    pin_blank_d = pin_blank_q;
    pin_row_d   = pin_row_q;
    is_data     = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScanEnable: scan_en_d = cfg_wdata_i[0];
        CfgFrameHold:  hold_d    = cfg_wdata_i;
      endcase
    end

    // Hold timer
    if (acc_i && (req_type_i == ReqMsTick)) begin
      if (ms_q >= hold_q) begin
        due_d = 1'b1;
      end else begin
        ms_d = ms_q + 16'd1;
      end
    end

    // Scan step
    if (tick && scan_en_q) begin
      unique case (phase_q)
        PhClkLow: begin
          pin_clk_d = 1'b0;
          if (col_q == ColW'(PanelColumns - 1)) begin
            col_d   = '0;
            phase_d = PhBlank;
          end else begin
            col_d   = col_q + ColW'(1);
            phase_d = PhData;
          end
        end
        PhBlank: begin
          pin_blank_d = 1'b1;
          phase_d     = PhLatch;
        end
        PhLatch: begin
          pin_latch_d = 1'b1;
          phase_d     = PhRow;
        end
        PhRow: begin
          pin_row_d = 4'(row_q);
          phase_d   = PhUnlatch;
        end
        PhUnlatch: begin
          pin_latch_d = 1'b0;
          phase_d     = PhUnblank;
        end
        PhUnblank: begin
          pin_blank_d = 1'b0;
          phase_d     = PhData;
          if (row_q == RowW'(ScanRows - 1)) begin
            row_d = '0;
            if (slot_q == BcmPlanes'(SlotCount - 1)) begin
              slot_d = '0;
              // end of pass: take the next scene if one is due
              if (due_q) begin
                scene_d = (scene_q == SceneW'(NumScenes - 1)) ? '0 : scene_q + SceneW'(1);
                ms_d    = '0;
                due_d   = 1'b0;
              end
            end else begin
              slot_d = slot_q + BcmPlanes'(1);
            end
          end else begin
            row_d = row_q + RowW'(1);
          end
        end
        default: begin
          // column data; a stray phase also lands here
          is_data   = 1'b1;
          pin_clk_d = 1'b1;
          phase_d   = PhClkLow;
        end
      endcase
    end
  end

  assign rd_en_o      = tick && is_data;
  assign beat_valid_o = tick;

  always_comb begin
    beat_o.is_data     = is_data;
    beat_o.bit_sel     = slot_bit(slot_q);
    beat_o.shift_clock = pin_clk_d;
    beat_o.latch       = pin_latch_d;
    beat_o.blank       = scan_en_q ? pin_blank_d : 1'b1;
    beat_o.row_select  = pin_row_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_en_q   <= 1'b0;
      hold_q      <= FrameHoldReset;
      phase_q     <= PhData;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      scene_q     <= '0;
      ms_q        <= '0;
      due_q       <= 1'b0;
      pin_clk_q   <= 1'b0;
      pin_latch_q <= 1'b0;
      pin_blank_q <= 1'b1;
      pin_row_q   <= '0;
    end else begin
      scan_en_q   <= scan_en_d;
      hold_q      <= hold_d;
      phase_q     <= phase_d;
      col_q       <= col_d;
      row_q       <= row_d;
      slot_q      <= slot_d;
      scene_q     <= scene_d;
      ms_q        <= ms_d;
      due_q       <= due_d;
      pin_clk_q   <= pin_clk_d;
      pin_latch_q <= pin_latch_d;
      pin_blank_q <= pin_blank_d;
      pin_row_q   <= pin_row_d;
    end
  end

endmodule

// ----- hw/rtl/ledbcm_out.sv -----
`timescale 1ns / 1ps

// Read-data stage and output register: merges store data into the pin word
module ledbcm_out import ledbcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_valid_i,
  input  beat_t             beat_i,
  input  logic [PixelW-1:0] top_pix_i,
  input  logic [PixelW-1:0] bot_pix_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        top_rgb_o,
  output logic [2:0]        bottom_rgb_o,
  output logic              shift_clock_o,
  output logic              latch_o,
  output logic              blank_o,
  output logic [3:0]        row_select_o
);

  logic       s1_valid_q, s1_valid_d;
  beat_t      s1_q;
  logic       out_valid_q, out_valid_d;
  logic [2:0] pin_top_q, pin_top_d;
  logic [2:0] pin_bot_q, pin_bot_d;
  logic       adv;
  logic       move;

  // Output register frees up when empty or drained this cycle
  assign adv    = !out_valid_q || out_ready_i;
  assign take_o = !s1_valid_q || adv;
  assign move   = s1_valid_q && adv;

  always_comb begin
    s1_valid_d  = take_o ? beat_valid_i : s1_valid_q;
    out_valid_d = adv ? s1_valid_q : out_valid_q;
    pin_top_d   = pin_top_q;
    pin_bot_d   = pin_bot_q;
    if (move && s1_q.is_data) begin
      pin_top_d = plane_rgb(top_pix_i, s1_q.bit_sel);
      pin_bot_d = plane_rgb(bot_pix_i, s1_q.bit_sel);
    end
  end

  // Control and held pin data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pin_top_q   <= '0;
      pin_bot_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pin_top_q   <= pin_top_d;
      pin_bot_q   <= pin_bot_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      s1_q <= beat_i;
    end
    if (move) begin
      top_rgb_o     <= pin_top_d;
      bottom_rgb_o  <= pin_bot_d;
      shift_clock_o <= s1_q.shift_clock;
      latch_o       <= s1_q.latch;
      blank_o       <= s1_q.blank;
      row_select_o  <= s1_q.row_select;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/led_matrix_bcm_scan_driver_unit.sv -----
`timescale 1ns / 1ps

// Scan driver for a 64x32 RGB LED panel scanned as 16 row pairs with binary code
// modulation over 5 bit planes (31 slots per pass). Input beats are pixel writes into
// a six-scene frame store, scan clock ticks, and millisecond ticks; only a scan tick
// returns a beat, the panel pin word after that step. One input beat is taken every
// cycle while results drain; a scan tick's pin word passes through the registered read
// of the frame store RAMs and then the output register. The frame stores have no reset
// and must be written before they are shown. Scene changes wait for the hold time and
// then for the end of a full pass.
module led_matrix_bcm_scan_driver_unit import ledbcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  scene_i,
  input  logic [4:0]  pixel_row_i,
  input  logic [5:0]  pixel_col_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  top_rgb_o,
  output logic [2:0]  bottom_rgb_o,
  output logic        shift_clock_o,
  output logic        latch_o,
  output logic        blank_o,
  output logic [3:0]  row_select_o
);

  logic              acc;
  logic              top_we, bot_we;
  logic [AddrW-1:0]  top_waddr, bot_waddr, rd_addr;
  logic [PixelW-1:0] wdata;
  logic              rd_en;
  logic              beat_valid;
  beat_t             beat;
  logic [PixelW-1:0] top_pix, bot_pix;

  assign acc = in_valid_i && in_ready_o;

  ledbcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .req_type_i  (req_type_i),
    .scene_i     (scene_i),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .top_we_o    (top_we),
    .bot_we_o    (bot_we),
    .top_waddr_o (top_waddr),
    .bot_waddr_o (bot_waddr),
    .wdata_o     (wdata),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .beat_valid_o(beat_valid),
    .beat_o      (beat)
  );

  // Top half frame store
  ledbcm_ram #(
    .Width(PixelW),
    .Depth(StoreDepth)
  ) u_top_ram (
    .clk_i  (clk_i),
    .we_i   (top_we),
    .waddr_i(top_waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(top_pix)
  );

  // Bottom half frame store
  ledbcm_ram #(
    .Width(PixelW),
    .Depth(StoreDepth)
  ) u_bot_ram (
    .clk_i  (clk_i),
    .we_i   (bot_we),
    .waddr_i(bot_waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(bot_pix)
  );

  ledbcm_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .top_pix_i    (top_pix),
    .bot_pix_i    (bot_pix),
    .take_o       (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .top_rgb_o    (top_rgb_o),
    .bottom_rgb_o (bottom_rgb_o),
    .shift_clock_o(shift_clock_o),
    .latch_o      (latch_o),
    .blank_o      (blank_o),
    .row_select_o (row_select_o)
  );

endmodule

// ----- hw/rtl/ledbcm_checker.sv -----
`timescale 1ns / 1ps
`include "led_matrix_bcm_scan_driver_unit_assert.svh"

// Port-level checks on the scan driver
module ledbcm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] top_rgb_o,
  input logic [2:0] bottom_rgb_o,
  input logic       shift_clock_o,
  input logic       latch_o,
  input logic       blank_o,
  input logic [3:0] row_select_o
);

  // Whole pin word as one vector
  logic [12:0] pin_word;

  assign pin_word = {top_rgb_o, bottom_rgb_o, shift_clock_o, latch_o, blank_o, row_select_o};

  // A stalled result beat stays offered
  `LEDBCM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // and its pin word does not move
  `LEDBCM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(pin_word))

  // Latch only pulses with the panel dark and the shift clock low
  `LEDBCM_ASSERT_IMPL(a_latch_dark, clk_i, rst_ni, out_valid_o && latch_o, blank_o && !shift_clock_o)

  // With the output register empty the input side is never held off
  `LEDBCM_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind led_matrix_bcm_scan_driver_unit ledbcm_checker u_ledbcm_checker (.*);
